// ===== rtl/tksi_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_pkg
// Shared types and constants for the top-k sorted insertion table.
// ---------------------------------------------------------------------------
package tksi_pkg;

    localparam int ENTRIES_DEF = 10;

    localparam int NAME_W  = 64;
    localparam int LEVEL_W = 8;
    localparam int SCORE_W = 32;
    localparam int DATE_W  = 32;
    localparam int RIDX_W  = 4;
    localparam int POS_W   = 4;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [LEVEL_W-1:0] level;
        logic [SCORE_W-1:0] score;
        logic [DATE_W-1:0]  date;
    } rec_t;

    // What one cell hands to the next one down the chain.
    typedef struct packed {
        logic valid;
        logic keep;
        rec_t rec;
    } cell_link_t;

endpackage : tksi_pkg
`default_nettype wire

// ===== rtl/tksi_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tksi_cell
// One rank slot: holds a record; on an insert it keeps it when its score
// beats the new one, otherwise takes the new record or the record of the slot above.
// ---------------------------------------------------------------------------
module tksi_cell
    import tksi_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       ins_en,
    input  wire rec_t       new_rec,
    input  wire cell_link_t up_link,
    output cell_link_t      dn_link
);

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;
    rec_t rec_next;
    logic keep;

    // Strictly greater holds its place, so ties let the newer record go first.
    assign keep = valid_reg && (rec_reg.score > new_rec.score);

    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ins_en && !keep) begin
            if (up_link.keep) begin
                valid_next = 1'b1;
                rec_next   = new_rec;
            end else begin
                valid_next = up_link.valid;
                rec_next   = up_link.rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign dn_link.valid = valid_reg;
    assign dn_link.keep  = keep;
    assign dn_link.rec   = rec_reg;

endmodule : tksi_cell
`default_nettype wire

// ===== rtl/top_k_sorted_insert_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_sorted_insert_core
// Score-sorted table of the best ENTRIES records with insert and read beats.
// ---------------------------------------------------------------------------
// Each beat's result appears in the output register the cycle after
// acceptance; a new beat is accepted every cycle while the result side keeps
// up. This rests on the row of cells: every cell compares its stored score
// with the incoming one in parallel and then holds, loads the new record or
// takes its upper neighbor's record in the same edge.
// A read beat selects one cell by read_index. No clearing pass is needed
// after reset; only the cell valid bits, entry count and output valid are cleared.
module top_k_sorted_insert_core
    import tksi_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [NAME_W-1:0]  s_new_name,
    input  wire logic [LEVEL_W-1:0] s_new_level,
    input  wire logic [SCORE_W-1:0] s_new_score,
    input  wire logic [DATE_W-1:0]  s_new_date,
    input  wire logic [RIDX_W-1:0]  s_read_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_inserted,
    output logic [POS_W-1:0]        m_position,
    output logic [POS_W-1:0]        m_entry_total,
    output logic                    m_entry_valid,
    output logic [NAME_W-1:0]       m_entry_name,
    output logic [LEVEL_W-1:0]      m_entry_level,
    output logic [SCORE_W-1:0]      m_entry_score,
    output logic [DATE_W-1:0]       m_entry_date
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic             s_fire;
    logic             ins_fire;
    rec_t             new_rec;
    cell_link_t       links [ENTRIES+1];
    logic [ENTRIES-1:0] valid_vec;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             placed;
    logic [POS_W-1:0] slot_pos;
    logic             rd_hit;
    rec_t             rd_rec;

    logic             m_valid_reg;
    logic             inserted_reg;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] total_reg;
    logic             evalid_reg;
    rec_t             erec_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign ins_fire = s_fire && (s_mode == MODE_INSERT);

    assign new_rec.name  = s_new_name;
    assign new_rec.level = s_new_level;
    assign new_rec.score = s_new_score;
    assign new_rec.date  = s_new_date;

    // Top of the chain: always "keeps", so cell 0 loads the new record unless it keeps its own.
    assign links[0].valid = 1'b1;
    assign links[0].keep  = 1'b1;
    assign links[0].rec   = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        tksi_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ins_en  (ins_fire),
            .new_rec (new_rec),
            .up_link (links[k]),
            .dn_link (links[k+1])
        );
        assign valid_vec[k] = links[k+1].valid;
    end

    // Keeps form a prefix; the cell where they stop takes the new record.
    // If the last cell still keeps, the table is full and the record loses.
    assign placed = !links[ENTRIES].keep;

    always_comb begin
        slot_pos = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (links[k].keep && !links[k+1].keep) begin
                slot_pos = slot_pos | POS_W'(k);
            end
        end
    end

    always_comb begin
        rd_rec = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (k == int'(s_read_index)) begin
                rd_rec = links[k+1].rec;
            end
        end
    end

    assign rd_hit = (int'(s_read_index) < int'(count_reg)) && (int'(s_read_index) < ENTRIES);

    always_comb begin
        count_next = count_reg;
        if (ins_fire && (count_reg < CNT_W'(ENTRIES))) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            total_reg <= POS_W'(count_next);
            if (s_mode == MODE_INSERT) begin
                inserted_reg <= placed;
                position_reg <= placed ? slot_pos : '0;
                evalid_reg   <= 1'b0;
                erec_reg     <= '0;
            end else begin
                inserted_reg <= 1'b0;
                position_reg <= '0;
                evalid_reg   <= rd_hit;
                erec_reg     <= rd_hit ? rd_rec : '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inserted    = inserted_reg;
    assign m_position    = position_reg;
    assign m_entry_total = total_reg;
    assign m_entry_valid = evalid_reg;
    assign m_entry_name  = erec_reg.name;
    assign m_entry_level = erec_reg.level;
    assign m_entry_score = erec_reg.score;
    assign m_entry_date  = erec_reg.date;

    // Valid cells and entry count must always agree.
    a_count_matches_cells : assert property (
        @(posedge aclk) disable iff (!aresetn)
        int'(count_reg) == $countones(valid_vec)
    ) else $error("entry count out of step with cell valid bits");

    a_count_bounded : assert property (
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES)
    ) else $error("entry count above table size");

    a_reject_only_when_full : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (ins_fire && !placed) |-> (count_reg == CNT_W'(ENTRIES))
    ) else $error("record rejected while table has room");

    a_append_grows : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (ins_fire && (count_reg < CNT_W'(ENTRIES))) |=>
            (count_reg == $past(count_reg) + CNT_W'(1))
    ) else $error("insert into non-full table did not grow count");

endmodule : top_k_sorted_insert_core
`default_nettype wire

// ===== sim/tksi_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tksi_checker
// Scoreboard for the top-k sorted insertion table.
// ---------------------------------------------------------------------------
// Keeps a shadow of the ranked table. It updates the shadow on every accepted
// input beat and queues the result beat that the table should return. Each
// accepted result beat is compared field by field with the oldest queued one.
module tksi_checker
    import tksi_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               s_mode,
    input  wire logic [NAME_W-1:0]  s_new_name,
    input  wire logic [LEVEL_W-1:0] s_new_level,
    input  wire logic [SCORE_W-1:0] s_new_score,
    input  wire logic [DATE_W-1:0]  s_new_date,
    input  wire logic [RIDX_W-1:0]  s_read_index,

    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic               m_inserted,
    input  wire logic [POS_W-1:0]   m_position,
    input  wire logic [POS_W-1:0]   m_entry_total,
    input  wire logic               m_entry_valid,
    input  wire logic [NAME_W-1:0]  m_entry_name,
    input  wire logic [LEVEL_W-1:0] m_entry_level,
    input  wire logic [SCORE_W-1:0] m_entry_score,
    input  wire logic [DATE_W-1:0]  m_entry_date,

    output int                      fail_count,
    output int                      results_due
);

    typedef struct packed {
        logic             inserted;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] total;
        logic             hit;
        rec_t             entry;
    } rank_outcome_t;

    rec_t          ranked [ENTRIES];
    int            fill;
    rank_outcome_t outcome_q [$];
    int            errors = 0;

    // Applies one beat to the shadow table and returns the result it causes.
    function automatic rank_outcome_t rank_step(input logic md, input rec_t rec,
                                                input logic [RIDX_W-1:0] idx);
        rank_outcome_t o;
        int            slot;
        int            last;
        bit            found;
        o = '0;
        if (md == MODE_INSERT) begin
            slot  = fill;
            found = 1'b0;
            // first entry not above the new score; ties put the new one first
            for (int k = 0; k < fill; k++) begin
                if (!found && ranked[k].score <= rec.score) begin
                    slot  = k;
                    found = 1'b1;
                end
            end
            if (slot < fill || fill < ENTRIES) begin
                last = (fill < ENTRIES) ? fill : ENTRIES - 1;
                for (int j = last; j > slot; j--)
                    ranked[j] = ranked[j-1];
                ranked[slot] = rec;
                if (fill < ENTRIES)
                    fill++;
                o.inserted = 1'b1;
                o.position = slot[POS_W-1:0];
            end
        end else if (idx < fill) begin
            o.hit   = 1'b1;
            o.entry = ranked[idx];
        end
        o.total = fill[POS_W-1:0];
        return o;
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        rec_t          offered;
        rank_outcome_t want;
        if (!aresetn) begin
            fill = 0;
            outcome_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                offered.name  = s_new_name;
                offered.level = s_new_level;
                offered.score = s_new_score;
                offered.date  = s_new_date;
                outcome_q.push_back(rank_step(s_mode, offered, s_read_index));
            end
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing outstanding", $time);
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("inserted", 64'(want.inserted), 64'(m_inserted));
                    compare_field("position", 64'(want.position), 64'(m_position));
                    compare_field("entry_total", 64'(want.total), 64'(m_entry_total));
                    compare_field("entry_valid", 64'(want.hit), 64'(m_entry_valid));
                    compare_field("entry_name", want.entry.name, m_entry_name);
                    compare_field("entry_level", 64'(want.entry.level), 64'(m_entry_level));
                    compare_field("entry_score", 64'(want.entry.score), 64'(m_entry_score));
                    compare_field("entry_date", 64'(want.entry.date), 64'(m_entry_date));
                end
            end
        end
        // visible to the stimulus side from the next edge on
        fail_count  <= errors;
        results_due <= outcome_q.size();
    end

endmodule : tksi_checker

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the top-k sorted insertion table.
// ---------------------------------------------------------------------------
// A directed walk fills the table through ties, appends, drops and a reject,
// then random insert and read beats with a slowly rising score band keep the
// ranking busy. Both channels idle at random; the result side holds off once
// for a long stretch and the input side pauses once until the table drains.
module tb_top;
    import tksi_pkg::*;

    localparam int RANDOM_BEATS = 1480;
    localparam int PAUSE_AT     = 700;
    localparam int LONG_HOLD    = 250;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int IDX_TOP      = 2**RIDX_W - 1;
    localparam int TIMEOUT_NS   = 6_000_000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [NAME_W-1:0]  s_new_name;
    logic [LEVEL_W-1:0] s_new_level;
    logic [SCORE_W-1:0] s_new_score;
    logic [DATE_W-1:0]  s_new_date;
    logic [RIDX_W-1:0]  s_read_index;
    logic               m_valid;
    logic               m_ready;
    logic               m_inserted;
    logic [POS_W-1:0]   m_position;
    logic [POS_W-1:0]   m_entry_total;
    logic               m_entry_valid;
    logic [NAME_W-1:0]  m_entry_name;
    logic [LEVEL_W-1:0] m_entry_level;
    logic [SCORE_W-1:0] m_entry_score;
    logic [DATE_W-1:0]  m_entry_date;

    int fail_count;
    int results_due;
    int inserts_sent = 0;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    top_k_sorted_insert_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_new_name(s_new_name), .s_new_level(s_new_level),
        .s_new_score(s_new_score), .s_new_date(s_new_date),
        .s_read_index(s_read_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_inserted(m_inserted),
        .m_position(m_position), .m_entry_total(m_entry_total),
        .m_entry_valid(m_entry_valid), .m_entry_name(m_entry_name),
        .m_entry_level(m_entry_level), .m_entry_score(m_entry_score),
        .m_entry_date(m_entry_date)
    );

    tksi_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_new_name(s_new_name), .s_new_level(s_new_level),
        .s_new_score(s_new_score), .s_new_date(s_new_date),
        .s_read_index(s_read_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_inserted(m_inserted),
        .m_position(m_position), .m_entry_total(m_entry_total),
        .m_entry_valid(m_entry_valid), .m_entry_name(m_entry_name),
        .m_entry_level(m_entry_level), .m_entry_score(m_entry_score),
        .m_entry_date(m_entry_date),
        .fail_count(fail_count), .results_due(results_due)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // Drives one beat and returns at the edge where it is accepted.
    task automatic offer(input mode_t md, input logic [NAME_W-1:0] nm,
                         input logic [LEVEL_W-1:0] lv, input logic [SCORE_W-1:0] sc,
                         input logic [DATE_W-1:0] dt, input logic [RIDX_W-1:0] idx);
        s_valid      <= 1'b1;
        s_mode       <= md;
        s_new_name   <= nm;
        s_new_level  <= lv;
        s_new_score  <= sc;
        s_new_date   <= dt;
        s_read_index <= idx;
        if (md == MODE_INSERT)
            inserts_sent++;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    initial begin : result_side
        int taken;
        int run_len;
        int stall;
        bit held;
        taken   = 0;
        held    = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run_len) begin
                @(posedge aclk);
                if (m_valid && m_ready)
                    taken++;
            end
            // one long hold-off lets the table back up into its input
            if (!held && taken >= HOLD_AFTER) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        static logic [SCORE_W-1:0] ladder [15] = '{32'd100, 32'd0, 32'd100, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 32'd50, 32'd200, 32'd7, 32'd1,
                                            32'd0, 32'd0, 32'd300, 32'd400, 32'd0, 32'd1};
        static logic [RIDX_W-1:0] probe [5] = '{4'd0, 4'd9, 4'd4, 4'd10, 4'd15};
        logic [SCORE_W-1:0] recent [8];
        logic [SCORE_W-1:0] band_base;
        logic [SCORE_W-1:0] sc;
        logic [RIDX_W-1:0]  idx;
        mode_t              md;
        int                 gap;
        int                 filled;
        int                 r;
        int                 waited;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_INSERT;
        s_new_name   <= '0;
        s_new_level  <= '0;
        s_new_score  <= '0;
        s_new_date   <= '0;
        s_read_index <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table: ranks 0, 9, 10 and 15 read back empty
        offer(MODE_READ, '0, '0, '0, '0, 4'd0);
        offer(MODE_READ, '1, '1, '1, '1, 4'd9);
        offer(MODE_READ, '0, '0, '0, '0, 4'd10);
        offer(MODE_READ, '1, '1, '1, '1, 4'd15);
        // appends, ties at top and bottom, fill, drop-off, reject, tie on last
        for (int k = 0; k < 15; k++) begin
            if (k == 0)
                offer(MODE_INSERT, '0, '0, ladder[k], '0, 4'd0);
            else if (k == 1)
                offer(MODE_INSERT, '1, '1, ladder[k], '1, 4'd15);
            else
                offer(MODE_INSERT, {$urandom, $urandom}, LEVEL_W'($urandom), ladder[k],
                      $urandom, RIDX_W'($urandom_range(0, IDX_TOP)));
        end
        for (int k = 0; k < 5; k++)
            offer(MODE_READ, {$urandom, $urandom}, LEVEL_W'($urandom), $urandom, $urandom,
                  probe[k]);

        band_base = $urandom_range(1000, 32'h7FFF_FFFF);
        for (int k = 0; k < 8; k++)
            recent[k] = band_base;

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // every 200 beats a run of back-to-back beats
            gap = ((n % 200) < 40) ? 0 : idle_gap();
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (results_due != 0)
                    @(posedge aclk);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end

            md = ($urandom_range(0, 9) < 3) ? MODE_READ : MODE_INSERT;
            if (md == MODE_READ) begin
                // mostly filled ranks; the rest at or past the fill point
                filled = (inserts_sent < ENTRIES_DEF) ? inserts_sent : ENTRIES_DEF;
                if (filled > 0 && $urandom_range(0, 9) < 8)
                    idx = RIDX_W'($urandom_range(0, filled - 1));
                else
                    idx = RIDX_W'($urandom_range(filled, IDX_TOP));
                sc = $urandom;
            end else begin
                idx = RIDX_W'($urandom_range(0, IDX_TOP));
                r   = $urandom_range(0, 99);
                if (r < 70)
                    sc = band_base + $urandom_range(0, 24);
                else if (r < 85)
                    sc = recent[$urandom_range(0, 7)];
                else
                    sc = $urandom_range(0, band_base);
                recent[n % 8] = sc;
                band_base     = band_base + $urandom_range(0, 2);
            end
            offer(md, {$urandom, $urandom}, LEVEL_W'($urandom), sc, $urandom, idx);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (results_due != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (results_due != 0)
            $display("%0t: %0d expected results never arrived", $time, results_due);
        if (fail_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_top
